FILE: rtl/c2e_pkg.sv
// ----------------------------------------------------------------------------
// c2e_pkg: shared types and constants for the calendar to epoch converter
// Holds the sequencer states, the command and status records between the
// controller and the datapath, the millisecond constants and the month
// length lookup.
// ----------------------------------------------------------------------------
package c2e_pkg;

    localparam int LAST_YEAR_DEF = 2099;

    localparam int MS_W    = 42;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int SCALE_W = 22;
    localparam int PROD_W  = 32;

    localparam logic [YEAR_W-1:0]  FIRST_YEAR  = 12'd1970;
    localparam logic [YEAR_W-1:0]  SHORT_YEAR  = 12'd2000;
    localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;

    localparam logic [MS_W-1:0] MS_1970_TO_2000 = 42'd946684800000;
    localparam logic [MS_W-1:0] MS_COMMON_YEAR  = 42'd31536000000;
    localparam logic [MS_W-1:0] MS_LEAP_YEAR    = 42'd31622400000;
    localparam logic [MS_W-1:0] MS_31_DAYS      = 42'd2678400000;
    localparam logic [MS_W-1:0] MS_30_DAYS      = 42'd2592000000;
    localparam logic [MS_W-1:0] MS_29_DAYS      = 42'd2505600000;
    localparam logic [MS_W-1:0] MS_28_DAYS      = 42'd2419200000;
    localparam logic [MS_W-1:0] MS_ONE_DAY      = 42'd86400000;

    localparam logic [23:0] MONTHS_COMMON = 24'hEEFBB3;
    localparam logic [23:0] MONTHS_LEAP   = 24'hEEFBB7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HOUR,
        S_MIN,
        S_SEC,
        S_MS,
        S_BASE,
        S_YEAR,
        S_TABLE,
        S_MONTH,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HOUR,
        OP_MIN,
        OP_SEC,
        OP_MS,
        OP_BASE,
        OP_YEAR,
        OP_TABLE,
        OP_MONTH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic year_done;
        logic month_done;
    } t_dp_sts;

    // two-bit month code: 11 = 31 days, 10 = 30, 01 = 29, 00 = 28
    function automatic logic [MS_W-1:0] month_ms(input logic [1:0] code);
        logic [MS_W-1:0] ms;
        case (code)
            2'b11:   ms = MS_31_DAYS;
            2'b10:   ms = MS_30_DAYS;
            2'b01:   ms = MS_29_DAYS;
            default: ms = MS_28_DAYS;
        endcase
        return ms;
    endfunction

endpackage

FILE: rtl/calendar_to_epoch_ms.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_ms: Gregorian date and time to milliseconds since epoch
// Converts year, month, day, hour, minute and second to milliseconds since
// 1970-01-01 00:00:00, with a range error for a bad month or year.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   -------------------------------------------
//  request   start / busy         i_year i_month i_day i_hour i_minute i_second
//  result    o_valid (strobe)     o_epoch_ms o_range_error
//
//  Sequence: a transaction is captured, then the time of day is scaled and the
//  base selected, then whole years are counted one per step (from 1970, or
//  from 2000 for later years; at most 29 or LAST_YEAR-2000), then the month
//  table is loaded and whole months are counted one per step, then the result
//  is strobed. The year loop sets the worst case for LAST_YEAR = 2099. A bad
//  month or year goes from capture straight to the result strobe.
//  Reset is synchronous and returns the sequencer to idle; no clearing pass.
//  The result is shown for exactly one cycle; the receiver cannot stall it.
//  busy is low again in the strobe cycle, so the next transaction can enter.
//
module calendar_to_epoch_ms #(
    parameter int LAST_YEAR = c2e_pkg::LAST_YEAR_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [c2e_pkg::YEAR_W-1:0]  i_year,
    input  logic [c2e_pkg::MONTH_W-1:0] i_month,
    input  logic [c2e_pkg::DAY_W-1:0]   i_day,
    input  logic [c2e_pkg::HOUR_W-1:0]  i_hour,
    input  logic [c2e_pkg::MIN_W-1:0]   i_minute,
    input  logic [c2e_pkg::SEC_W-1:0]   i_second,
    output logic                        o_valid,
    output logic [c2e_pkg::MS_W-1:0]    o_epoch_ms,
    output logic                        o_range_error
);

    c2e_pkg::t_dp_cmd w_cmd;
    c2e_pkg::t_dp_sts w_sts;

    // sequencer: issue at most one datapath command per cycle
    c2e_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_valid (o_valid)
    );

    // datapath: hold the transaction and accumulate milliseconds
    c2e_dp #(
        .LAST_YEAR (LAST_YEAR)
    ) u_dp (
        .i_clk         (i_clk),
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_epoch_ms    (o_epoch_ms),
        .o_range_error (o_range_error)
    );

`ifndef NO_ASSERTIONS
    // strobe lasts one cycle only
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // an error result carries zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_epoch_ms == '0))
        else $error("range error with non-zero time");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    // the strobe never shows while a transaction is at work
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");
`endif

endmodule

FILE: rtl/c2e_dp.sv
// ----------------------------------------------------------------------------
// c2e_dp: datapath of the calendar to epoch converter
// Captures the transaction, scales the time of day, then accumulates whole
// years and whole months one per command.
// ----------------------------------------------------------------------------
module c2e_dp #(
    parameter int LAST_YEAR = c2e_pkg::LAST_YEAR_DEF
) (
    input  logic                          i_clk,
    input  logic [c2e_pkg::YEAR_W-1:0]    i_year,
    input  logic [c2e_pkg::MONTH_W-1:0]   i_month,
    input  logic [c2e_pkg::DAY_W-1:0]     i_day,
    input  logic [c2e_pkg::HOUR_W-1:0]    i_hour,
    input  logic [c2e_pkg::MIN_W-1:0]     i_minute,
    input  logic [c2e_pkg::SEC_W-1:0]     i_second,
    input  c2e_pkg::t_dp_cmd              i_cmd,
    output c2e_pkg::t_dp_sts              o_sts,
    output logic [c2e_pkg::MS_W-1:0]      o_epoch_ms,
    output logic                          o_range_error
);

    logic [c2e_pkg::YEAR_W-1:0]  r_year,   n_year;
    logic [c2e_pkg::MONTH_W-1:0] r_month,  n_month;
    logic [c2e_pkg::DAY_W-1:0]   r_day,    n_day;
    logic [c2e_pkg::HOUR_W-1:0]  r_hour,   n_hour;
    logic [c2e_pkg::MIN_W-1:0]   r_minute, n_minute;
    logic [c2e_pkg::SEC_W-1:0]   r_second, n_second;
    logic                        r_err,    n_err;
    logic [c2e_pkg::SCALE_W-1:0] r_scale,  n_scale;
    logic [c2e_pkg::MS_W-1:0]    r_acc,    n_acc;
    logic [c2e_pkg::YEAR_W-1:0]  r_y,      n_y;
    logic [1:0]                  r_m4,     n_m4;
    logic [6:0]                  r_m100,   n_m100;
    logic [8:0]                  r_m400,   n_m400;
    logic [23:0]                 r_tab,    n_tab;
    logic [c2e_pkg::MONTH_W-1:0] r_k,      n_k;

    logic                        w_leap;
    logic                        w_bad;
    logic [c2e_pkg::PROD_W-1:0]  w_prod;

    // leap rule from the running residues of the year counter
    assign w_leap = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));

    assign w_bad = (i_month == '0) || (i_month > c2e_pkg::LAST_MONTH)
                || (i_year < c2e_pkg::FIRST_YEAR)
                || (32'(i_year) > 32'(LAST_YEAR));

    assign w_prod = c2e_pkg::PROD_W'(r_scale) * 32'd1000;

    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_err    = r_err;
        n_scale  = r_scale;
        n_acc    = r_acc;
        n_y      = r_y;
        n_m4     = r_m4;
        n_m100   = r_m100;
        n_m400   = r_m400;
        n_tab    = r_tab;
        n_k      = r_k;
        case (i_cmd.op)
            c2e_pkg::OP_LOAD: begin
                n_year   = i_year;
                n_month  = i_month;
                n_day    = i_day;
                n_hour   = i_hour;
                n_minute = i_minute;
                n_second = i_second;
                n_err    = w_bad;
            end
            c2e_pkg::OP_HOUR: begin
                n_scale = c2e_pkg::SCALE_W'(r_hour)
                        + c2e_pkg::SCALE_W'(r_day) * 22'd24;
            end
            c2e_pkg::OP_MIN: begin
                n_scale = c2e_pkg::SCALE_W'(r_minute) + r_scale * 22'd60;
            end
            c2e_pkg::OP_SEC: begin
                n_scale = c2e_pkg::SCALE_W'(r_second) + r_scale * 22'd60;
            end
            c2e_pkg::OP_MS: begin
                // day is one-based: drop one day, wrapping for day zero
                n_acc = c2e_pkg::MS_W'(w_prod) - c2e_pkg::MS_ONE_DAY;
            end
            c2e_pkg::OP_BASE: begin
                if (r_year >= c2e_pkg::SHORT_YEAR) begin
                    n_acc  = r_acc + c2e_pkg::MS_1970_TO_2000;
                    n_y    = c2e_pkg::SHORT_YEAR;
                    n_m4   = 2'd0;
                    n_m100 = 7'd0;
                    n_m400 = 9'd0;
                end else begin
                    n_y    = c2e_pkg::FIRST_YEAR;
                    n_m4   = 2'd2;
                    n_m100 = 7'd70;
                    n_m400 = 9'd370;
                end
            end
            c2e_pkg::OP_YEAR: begin
                n_acc  = r_acc + (w_leap ? c2e_pkg::MS_LEAP_YEAR
                                         : c2e_pkg::MS_COMMON_YEAR);
                n_y    = r_y + 12'd1;
                n_m4   = r_m4 + 2'd1;
                n_m100 = (r_m100 == 7'd99)  ? 7'd0 : r_m100 + 7'd1;
                n_m400 = (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
            end
            c2e_pkg::OP_TABLE: begin
                n_tab = w_leap ? c2e_pkg::MONTHS_LEAP : c2e_pkg::MONTHS_COMMON;
                n_k   = 4'd1;
            end
            c2e_pkg::OP_MONTH: begin
                n_acc = r_acc + c2e_pkg::month_ms(r_tab[1:0]);
                n_tab = {2'b00, r_tab[23:2]};
                n_k   = r_k + 4'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_second <= n_second;
        r_err    <= n_err;
        r_scale  <= n_scale;
        r_acc    <= n_acc;
        r_y      <= n_y;
        r_m4     <= n_m4;
        r_m100   <= n_m100;
        r_m400   <= n_m400;
        r_tab    <= n_tab;
        r_k      <= n_k;
    end

    assign o_sts.err        = r_err;
    assign o_sts.year_done  = (r_y == r_year);
    assign o_sts.month_done = (r_k == r_month);

    assign o_epoch_ms    = r_err ? '0 : r_acc;
    assign o_range_error = r_err;

endmodule

FILE: rtl/c2e_ctrl.sv
// ----------------------------------------------------------------------------
// c2e_ctrl: sequencer of the calendar to epoch converter
// Steps the datapath through capture, time scaling, the year loop and the
// month loop (skipping all on a range error), and raises the result strobe.
// ----------------------------------------------------------------------------
module c2e_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  c2e_pkg::t_dp_sts i_sts,
    output c2e_pkg::t_dp_cmd o_cmd,
    output logic             o_valid
);

    c2e_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c2e_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = c2e_pkg::OP_NONE;
        busy     = 1'b1;
        o_valid  = 1'b0;
        case (r_state)
            c2e_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.op = c2e_pkg::OP_LOAD;
                    n_state  = c2e_pkg::S_HOUR;
                end
            end
            c2e_pkg::S_HOUR: begin
                if (i_sts.err) begin
                    n_state = c2e_pkg::S_DONE;
                end else begin
                    o_cmd.op = c2e_pkg::OP_HOUR;
                    n_state  = c2e_pkg::S_MIN;
                end
            end
            c2e_pkg::S_MIN: begin
                o_cmd.op = c2e_pkg::OP_MIN;
                n_state  = c2e_pkg::S_SEC;
            end
            c2e_pkg::S_SEC: begin
                o_cmd.op = c2e_pkg::OP_SEC;
                n_state  = c2e_pkg::S_MS;
            end
            c2e_pkg::S_MS: begin
                o_cmd.op = c2e_pkg::OP_MS;
                n_state  = c2e_pkg::S_BASE;
            end
            c2e_pkg::S_BASE: begin
                o_cmd.op = c2e_pkg::OP_BASE;
                n_state  = c2e_pkg::S_YEAR;
            end
            c2e_pkg::S_YEAR: begin
                if (i_sts.year_done) begin
                    n_state = c2e_pkg::S_TABLE;
                end else begin
                    o_cmd.op = c2e_pkg::OP_YEAR;
                end
            end
            c2e_pkg::S_TABLE: begin
                o_cmd.op = c2e_pkg::OP_TABLE;
                n_state  = c2e_pkg::S_MONTH;
            end
            c2e_pkg::S_MONTH: begin
                if (i_sts.month_done) begin
                    n_state = c2e_pkg::S_DONE;
                end else begin
                    o_cmd.op = c2e_pkg::OP_MONTH;
                end
            end
            c2e_pkg::S_DONE: begin
                // result on the ports; a new transaction may enter now
                busy    = 1'b0;
                o_valid = 1'b1;
                if (start) begin
                    o_cmd.op = c2e_pkg::OP_LOAD;
                    n_state  = c2e_pkg::S_HOUR;
                end else begin
                    n_state  = c2e_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = c2e_pkg::S_IDLE;
            end
        endcase
    end

endmodule
